### src/fspa_pkg.sv
// Shared types and constants of the fixed-size pool allocator.
// Stand-alone package; used by the top level fixed_size_pool_allocator.
package fspa_pkg;

  localparam int unsigned OPCODE_W  = 1;
  localparam int unsigned SIZE_W    = 16;
  localparam int unsigned HANDLE_W  = 10;
  localparam int unsigned SLOT_W    = 10;
  localparam int unsigned STATUS_W  = 2;
  localparam int unsigned COUNT_W   = 11;

  // stream words: request {handle, request_size}, response {allocated_count, slot}
  localparam int unsigned IN_TDATA_W  = 32;
  localparam int unsigned OUT_TDATA_W = 24;

  localparam logic [SIZE_W-1:0] ITEM_SIZE_RST = 16'd1;

  typedef enum logic [OPCODE_W-1:0] {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } opcode_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK         = 2'd0,
    ST_EXHAUSTED  = 2'd1,
    ST_SIZE       = 2'd2,
    ST_BAD_HANDLE = 2'd3
  } status_e;

endpackage

### src/fspa_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module fspa_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

### src/fixed_size_pool_allocator.sv
// Top level of the fixed-size slot pool allocator with its LIFO free list.
// Depends on fspa_pkg and fspa_ram (free-list link memory).
//
// Usage:
//  - Request words enter on s_axis: tuser is the opcode (allocate or free),
//    tdata carries the stated item size and, for a free, the slot handle.
//  - One response word per request leaves on m_axis: tuser is the status,
//    tdata carries the granted slot and the allocated count after the request.
//  - cfg_* writes the expected item size; write it only while no request is
//    in flight.
//  - A request is handled in steps: the accept cycle issues the read of the
//    free-list link at the current head; in S_EXEC, once the response register
//    is free, the block uses the read data, updates head, watermark and count,
//    and loads the response register. A new request is taken only after the
//    previous one has loaded its response.
//  - The response register parts both sides: a request is accepted while the
//    previous response waits. If the receiver stalls, the block holds the
//    finished request until the response register frees up.
//  - Reset empties the free list, clears watermark and count, and sets the
//    item size to 1. The link memory needs no clearing pass.
module fixed_size_pool_allocator #(
  parameter int unsigned POOL_SLOTS = 1024
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // [15:0] request_size, [25:16] handle, [31:26] zero
  input  logic [fspa_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  // [0] opcode
  input  logic [fspa_pkg::OPCODE_W-1:0]    s_axis_tuser,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // [9:0] slot, [20:10] allocated_count, [23:21] zero
  output logic [fspa_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  // [1:0] status
  output logic [fspa_pkg::STATUS_W-1:0]    m_axis_tuser,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [fspa_pkg::SIZE_W-1:0]      cfg_data_i
);

  import fspa_pkg::*;

  localparam int unsigned IW   = $clog2(POOL_SLOTS);
  localparam int unsigned CW   = IW + 1;
  localparam int unsigned CMPW = (CW > HANDLE_W) ? CW : HANDLE_W;
  localparam int unsigned WW   = (CMPW > COUNT_W) ? CMPW : COUNT_W;
  localparam logic [CW-1:0]   POOL_C = CW'(POOL_SLOTS);
  localparam logic [CMPW-1:0] POOL_X = CMPW'(POOL_SLOTS);
  localparam int unsigned OUT_PAD = OUT_TDATA_W - SLOT_W - COUNT_W;

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_e;

  state_e            state_q, state_d;
  logic [SIZE_W-1:0] item_size_q, item_size_d;
  logic [CW-1:0]     head_q, head_d;
  logic [CW-1:0]     fresh_q, fresh_d;
  logic [CW-1:0]     live_q, live_d;
  opcode_e           op_q, op_d;
  logic [SIZE_W-1:0] req_size_q, req_size_d;
  logic [HANDLE_W-1:0] handle_q, handle_d;
  logic              out_valid_q, out_valid_d;
  logic [SLOT_W-1:0] out_slot_q, out_slot_d;
  logic [COUNT_W-1:0] out_count_q, out_count_d;
  status_e           out_status_q, out_status_d;

  logic              in_acc, load;
  logic              mem_we, mem_re;
  logic [IW-1:0]     mem_waddr;
  logic [CW-1:0]     link_rdata;
  logic [CMPW-1:0]   handle_x;
  logic [CW-1:0]     res_slot;
  status_e           res_status;
  logic [WW-1:0]     slot_w, live_w;

  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state_q == S_IDLE);
  assign load          = (state_q == S_EXEC) && (!out_valid_q || m_axis_tready);
  assign mem_re        = in_acc && (head_q < POOL_C);
  assign handle_x      = CMPW'(handle_q);
  assign mem_waddr     = handle_x[IW-1:0];
  assign cfg_ready_o   = 1'b1;

  fspa_ram #(
    .WIDTH (CW),
    .DEPTH (POOL_SLOTS)
  ) u_link_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (head_q),
    .re_i    (mem_re),
    .raddr_i (head_q[IW-1:0]),
    .rdata_o (link_rdata)
  );

  always_comb begin
    state_d      = state_q;
    item_size_d  = item_size_q;
    head_d       = head_q;
    fresh_d      = fresh_q;
    live_d       = live_q;
    op_d         = op_q;
    req_size_d   = req_size_q;
    handle_d     = handle_q;
    out_valid_d  = out_valid_q;
    out_slot_d   = out_slot_q;
    out_count_d  = out_count_q;
    out_status_d = out_status_q;
    mem_we       = 1'b0;
    res_slot     = '0;
    res_status   = ST_OK;
    slot_w       = '0;
    live_w       = '0;

    if (cfg_valid_i) begin
      item_size_d = cfg_data_i;
    end

    if (out_valid_q && m_axis_tready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          op_d       = opcode_e'(s_axis_tuser);
          req_size_d = s_axis_tdata[SIZE_W-1:0];
          handle_d   = s_axis_tdata[SIZE_W +: HANDLE_W];
          state_d    = S_EXEC;
        end
      end
      S_EXEC: begin
        if (load) begin
          if (req_size_q != item_size_q) begin
            res_status = ST_SIZE;
          end else if (op_q == OP_ALLOC) begin
            if (live_q >= POOL_C) begin
              res_status = ST_EXHAUSTED;
            end else if (head_q < POOL_C) begin
              res_slot = head_q;
              head_d   = link_rdata;
              live_d   = live_q + 1'b1;
            end else if (fresh_q < POOL_C) begin
              res_slot = fresh_q;
              fresh_d  = fresh_q + 1'b1;
              live_d   = live_q + 1'b1;
            end else begin
              res_status = ST_EXHAUSTED;
            end
          end else begin
            if (handle_x >= POOL_X || handle_x >= CMPW'(fresh_q) || live_q == '0) begin
              res_status = ST_BAD_HANDLE;
            end else begin
              mem_we = 1'b1;
              head_d = CW'(handle_x);
              live_d = live_q - 1'b1;
            end
          end
          slot_w       = WW'(res_slot);
          live_w       = WW'(live_d);
          out_slot_d   = slot_w[SLOT_W-1:0];
          out_count_d  = live_w[COUNT_W-1:0];
          out_status_d = res_status;
          out_valid_d  = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      item_size_q <= ITEM_SIZE_RST;
      head_q      <= POOL_C;
      fresh_q     <= '0;
      live_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      item_size_q <= item_size_d;
      head_q      <= head_d;
      fresh_q     <= fresh_d;
      live_q      <= live_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q         <= op_d;
    req_size_q   <= req_size_d;
    handle_q     <= handle_d;
    out_slot_q   <= out_slot_d;
    out_count_q  <= out_count_d;
    out_status_q <= out_status_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{OUT_PAD{1'b0}}, out_count_q, out_slot_q};
  assign m_axis_tuser  = out_status_q;

  a_live_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    live_q <= POOL_C && fresh_q <= POOL_C)
    else $error("pool count or watermark beyond pool size");

  a_resp_from_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_EXEC))
    else $error("response appeared without an executed request");

  a_alloc_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load && op_q == OP_ALLOC && res_status == ST_OK) |=> live_q == $past(live_q) + 1'b1)
    else $error("successful allocate did not raise the count");

  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> state_q == S_EXEC && !s_axis_tready)
    else $error("request accepted while another is executing");

endmodule
